/* hw/rtl/pdle_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and helpers of the packet delay and loss emulator
// no dependencies

package pdle_pkg;

    localparam int DATA_W = 32;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int CFG_ADDR_W = 4;

    localparam logic [1:0] REG_DELAY_MIN = 2'd0;
    localparam logic [1:0] REG_DELAY_MAX = 2'd1;
    localparam logic [1:0] REG_LOSS_THR = 2'd2;

    localparam logic [16:0] LOSS_THR_RST = 17'd1638;

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
        logic [DATA_W-1:0] stamp;
        logic [DATA_W-1:0] due;
        logic              lost;
    } entry_t;

    typedef struct packed {
        logic   ins;
        logic   pop;
        entry_t new_entry;
    } cell_ctrl_t;

    function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
        sat_inc = (v == {DATA_W{1'b1}}) ? v : v + DATA_W'(1);
    endfunction

endpackage

/* hw/rtl/pdle_cell.sv */
`timescale 1ns / 1ps
// one cell of the sorted delay queue: holds one entry, shifts right on insert
// and left on pop; depends on pdle_pkg

module pdle_cell (
    input  logic                aclk,
    input  logic                valid,
    input  logic                gt_in,
    input  pdle_pkg::entry_t    left_entry,
    input  pdle_pkg::entry_t    right_entry,
    input  pdle_pkg::cell_ctrl_t ctrl,
    output logic                gt_out,
    output pdle_pkg::entry_t    entry
);

    pdle_pkg::entry_t entry_reg;
    pdle_pkg::entry_t entry_next;

    // empty cells count as later than any new entry
    assign gt_out = !valid || (entry_reg.due > ctrl.new_entry.due);
    assign entry  = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins && gt_out) begin
            entry_next = gt_in ? left_entry : ctrl.new_entry;
        end else if (ctrl.pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

/* hw/rtl/packet_delay_loss_emulator_core.sv */
`timescale 1ns / 1ps
// packet delay and loss emulator: delay calc, row of sorted queue cells,
// head pop and counters; depends on pdle_pkg and pdle_cell
// steps from input beat to result beat: accept/multiply, add, insert, pop; pop waits for a free output
// a new beat is taken only after the last one has left its pop step; the insert and pop share the cell row
// a finished result waits in the output register while the next beat is taken
// reset: synchronous active-low aresetn clears queue fill, held sample, counters and delay
// registers and loads the loss threshold reset value; no clearing pass is needed

module packet_delay_loss_emulator_core #(
    parameter int QUEUE_DEPTH = pdle_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // now, value_x, value_y, value_z, random_draw
    input  logic [143:0]                    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_x, out_y, out_z, out_stamp, lost_total, sent_total
    output logic [191:0]                    m_tdata,
    // delivered, discarded
    output logic [1:0]                      m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pdle_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = pdle_pkg::DATA_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ADD  = 4'b0010,
        ST_INS  = 4'b0100,
        ST_POP  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]      delay_min_reg, delay_max_reg;
    logic [16:0]      loss_thr_reg;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [DW-1:0]    held_x_reg, held_y_reg, held_z_reg, held_stamp_reg;
    logic [DW-1:0]    held_x_next, held_y_next, held_z_next, held_stamp_next;
    logic [DW-1:0]    lost_reg, lost_next, sent_reg;
    logic             delivered_reg, delivered_next, discarded_reg, discarded_next;
    logic [15:0]      frac_reg;
    pdle_pkg::entry_t new_reg;
    logic [191:0]     m_tdata_reg;
    logic [1:0]       m_tuser_reg;
    logic             m_tvalid_reg;

    logic             accept, cfg_wr, out_free, full, head_due, keep;
    logic [15:0]      span, draw;
    logic [31:0]      prod;
    logic [33:0]      due_sum;
    pdle_pkg::cell_ctrl_t ctrl;

    pdle_pkg::entry_t entry_q [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] gt_q;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_min_reg <= '0;
            delay_max_reg <= '0;
            loss_thr_reg  <= pdle_pkg::LOSS_THR_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                pdle_pkg::REG_DELAY_MIN: delay_min_reg <= pwdata[15:0];
                pdle_pkg::REG_DELAY_MAX: delay_max_reg <= pwdata[15:0];
                pdle_pkg::REG_LOSS_THR:  loss_thr_reg  <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pdle_pkg::REG_DELAY_MIN: prdata = {16'd0, delay_min_reg};
            pdle_pkg::REG_DELAY_MAX: prdata = {16'd0, delay_max_reg};
            pdle_pkg::REG_LOSS_THR:  prdata = {15'd0, loss_thr_reg};
            default:                 prdata = '0;
        endcase
    end

    // input side and delay calc
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign draw     = s_tdata[143:128];
    assign span     = (delay_max_reg > delay_min_reg) ? (delay_max_reg - delay_min_reg) : 16'd0;
    assign prod     = span * draw;
    assign due_sum  = {2'b00, new_reg.stamp} + {18'd0, delay_min_reg} + {18'd0, frac_reg};

    always_ff @(posedge aclk) begin
        if (accept) begin
            frac_reg      <= prod[31:16];
            new_reg.stamp <= s_tdata[31:0];
            new_reg.x     <= s_tdata[63:32];
            new_reg.y     <= s_tdata[95:64];
            new_reg.z     <= s_tdata[127:96];
            new_reg.lost  <= ({1'b0, draw} < loss_thr_reg);
        end
        if (state_reg == ST_ADD) begin
            new_reg.due <= (due_sum[33:32] != 2'b00) ? {DW{1'b1}} : due_sum[31:0];
        end
    end

    // cell row
    assign full      = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign head_due  = (occ_reg != '0) && (entry_q[0].due <= new_reg.stamp);
    assign keep      = !entry_q[0].lost && (entry_q[0].stamp > held_stamp_reg);

    assign ctrl.ins       = (state_reg == ST_INS) && !full;
    assign ctrl.pop       = (state_reg == ST_POP) && out_free && head_due;
    assign ctrl.new_entry = new_reg;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        pdle_cell u_cell (
            .aclk        (aclk),
            .valid       (occ_reg > OCC_W'(i)),
            .gt_in       ((i == 0) ? 1'b0 : gt_q[(i == 0) ? 0 : i-1]),
            .left_entry  (entry_q[(i == 0) ? 0 : i-1]),
            .right_entry (entry_q[(i == QUEUE_DEPTH-1) ? i : i+1]),
            .ctrl        (ctrl),
            .gt_out      (gt_q[i]),
            .entry       (entry_q[i])
        );
    end

    // sequencing, held sample and counters
    always_comb begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        lost_next       = lost_reg;
        delivered_next  = delivered_reg;
        discarded_next  = discarded_reg;
        held_x_next     = held_x_reg;
        held_y_next     = held_y_reg;
        held_z_next     = held_z_reg;
        held_stamp_next = held_stamp_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next     = ST_ADD;
                    delivered_next = 1'b0;
                    discarded_next = 1'b0;
                end
            end
            ST_ADD: state_next = ST_INS;
            ST_INS: begin
                state_next = ST_POP;
                if (full) begin
                    lost_next      = pdle_pkg::sat_inc(lost_reg);
                    discarded_next = 1'b1;
                end else begin
                    occ_next = occ_reg + OCC_W'(1);
                end
            end
            ST_POP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    if (head_due) begin
                        occ_next = occ_reg - OCC_W'(1);
                        if (keep) begin
                            held_x_next     = entry_q[0].x;
                            held_y_next     = entry_q[0].y;
                            held_z_next     = entry_q[0].z;
                            held_stamp_next = entry_q[0].stamp;
                            delivered_next  = 1'b1;
                        end else begin
                            lost_next      = pdle_pkg::sat_inc(lost_reg);
                            discarded_next = 1'b1;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            occ_reg        <= '0;
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            held_z_reg     <= '0;
            held_stamp_reg <= '0;
            lost_reg       <= '0;
            sent_reg       <= '0;
            delivered_reg  <= 1'b0;
            discarded_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            held_x_reg     <= held_x_next;
            held_y_reg     <= held_y_next;
            held_z_reg     <= held_z_next;
            held_stamp_reg <= held_stamp_next;
            lost_reg       <= lost_next;
            delivered_reg  <= delivered_next;
            discarded_reg  <= discarded_next;
            if (accept) begin
                sent_reg <= pdle_pkg::sat_inc(sent_reg);
            end
            if (state_reg == ST_POP && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_POP && out_free) begin
            m_tdata_reg <= {sent_reg, lost_next, held_stamp_next,
                            held_z_next, held_y_next, held_x_next};
            m_tuser_reg <= {discarded_next, delivered_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_reg >= OCC_W'(2)) |-> (entry_q[0].due <= entry_q[1].due))
        else $error("queue head out of due order");

    a_result_from_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_POP))
        else $error("result beat outside pop step");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_ADD))
        else $error("accepted beat did not start delay calc");
`endif

endmodule
